// ===== hdl/cltok_pkg.sv =====
// Shared types and constants for the command-line tokenizer.
package cltok_pkg;

  // Config register indexes
  localparam logic [1:0] REG_ARG_LIMIT      = 2'd0;
  localparam logic [1:0] REG_WORD_LIMIT     = 2'd1;
  localparam logic [1:0] REG_ARG_BYTE_LIMIT = 2'd2;
  localparam logic [1:0] REG_COMMAND_LIMIT  = 2'd3;

  // Result queue geometry
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_PIPE = 2'd2,
    KIND_STMT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2,
    ST_SOLE  = 2'd3
  } stat_t;

  typedef struct packed {
    logic [7:0]  arg_limit;
    logic [11:0] word_limit;
    logic [15:0] arg_byte_limit;
    logic [4:0]  command_limit;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [7:0]  arg;
    logic [3:0]  cmd;
    logic [11:0] len;
    stat_t       st;
    logic [4:0]  tot;
    logic        last;
  } res_t;

  // Up to three results written into the queue in the same cycle
  typedef struct packed {
    logic [1:0]       n;
    res_t [2:0]       r;
  } push_t;

endpackage

// ===== hdl/cltok_front.sv =====
// Lexer front end: takes one item per cycle while the queue has room and produces its results.
module cltok_front import cltok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_eoi,
  input  logic [7:0] in_byte,
  input  logic       room,
  output push_t      push
);

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_WORD    = 3'd1,
    M_QUOTE   = 3'd2,
    M_ESC     = 3'd3,
    M_SLASH   = 3'd4,
    M_PIPE    = 3'd5,
    M_COMMENT = 3'd6,
    M_DISCARD = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] wcnt;
    logic [7:0]  argc;
    logic [15:0] bytes;
    logic [4:0]  cmdc;
    logic        cmd_seen;
    logic [2:0]  mpos;
    logic        first_st;
    logic        sole_seen;
  } lex_t;

  localparam logic [2:0] MATCH_DONE = 3'd6;
  localparam logic [2:0] MATCH_FAIL = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  lex_t  lex, lex_next;
  push_t emit;
  logic  accept;

  function automatic logic [7:0] status_char(input logic [2:0] pos);
    case (pos)
      3'd0:    return 8'h73; // s
      3'd1:    return 8'h74; // t
      3'd2:    return 8'h61; // a
      3'd3:    return 8'h74; // t
      3'd4:    return 8'h75; // u
      default: return 8'h73; // s
    endcase
  endfunction

  function automatic logic bare_byte(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
           (c inside {8'h5F, 8'h2E, 8'h2F, 8'h2C, 8'h3A, 8'h2B, 8'h3D, 8'h40,
                      8'h25, 8'h2D});
  endfunction

  function automatic logic separator(input logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [7:0] ch,
                                  input logic [7:0] arg, input logic [3:0] cmd,
                                  input logic [11:0] len, input stat_t st,
                                  input logic [4:0] tot);
    res_t r;
    r.kind = k;
    r.ch   = ch;
    r.arg  = arg;
    r.cmd  = cmd;
    r.len  = len;
    r.st   = st;
    r.tot  = tot;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void put(inout push_t e, input res_t r);
    if (e.n != 2'd3) begin
      e.r[e.n] = r;
      e.n = e.n + 2'd1;
    end
  endfunction

  function automatic void clear_command(inout lex_t s);
    s.wcnt     = '0;
    s.argc     = '0;
    s.bytes    = '0;
    s.cmd_seen = 1'b0;
    s.mpos     = '0;
    s.first_st = 1'b0;
  endfunction

  function automatic void clear_statement(inout lex_t s);
    clear_command(s);
    s.mode      = M_BETWEEN;
    s.cmdc      = '0;
    s.sole_seen = 1'b0;
  endfunction

  function automatic void begin_word(inout lex_t s);
    s.wcnt = '0;
    s.mpos = '0;
  endfunction

  function automatic logic add_char(inout lex_t s, inout push_t e, input cfg_t c,
                                    input logic [7:0] ch);
    if (s.wcnt >= c.word_limit) return 1'b0;
    if (s.argc == 8'd0) begin
      if (s.mpos < MATCH_DONE && ch == status_char(s.mpos)) s.mpos = s.mpos + 3'd1;
      else s.mpos = MATCH_FAIL;
    end
    s.wcnt = s.wcnt + 12'd1;
    put(e, mk_res(KIND_CHAR, ch, s.argc, s.cmdc[3:0], 12'd0, ST_OK, 5'd0));
    return 1'b1;
  endfunction

  function automatic logic end_word(inout lex_t s, inout push_t e, input cfg_t c);
    logic [17:0] sum;
    sum = {2'b00, s.bytes} + {6'd0, s.wcnt} + 18'd1;
    if (s.argc >= c.arg_limit) return 1'b0;
    if (s.wcnt > c.word_limit) return 1'b0;
    if (sum > {2'b00, c.arg_byte_limit}) return 1'b0;
    s.bytes = sum[15:0];
    put(e, mk_res(KIND_END, 8'd0, s.argc, s.cmdc[3:0], s.wcnt, ST_OK, 5'd0));
    if (s.argc == 8'd0) s.first_st = (s.mpos == MATCH_DONE);
    s.argc     = s.argc + 8'd1;
    s.cmd_seen = 1'b1;
    s.wcnt     = '0;
    s.mpos     = '0;
    return 1'b1;
  endfunction

  function automatic void finish_statement(inout lex_t s, inout push_t e);
    stat_t      st;
    logic [4:0] tot;
    logic       sole;
    sole = s.first_st && (s.argc == 8'd1);
    if (s.mode == M_DISCARD) st = ST_ERROR;
    else if (!s.cmd_seen && s.cmdc == 5'd0) st = ST_EMPTY;
    else if (!s.cmd_seen) st = ST_ERROR;
    else if (s.cmdc != 5'd0) st = (s.sole_seen || sole) ? ST_ERROR : ST_OK;
    else st = sole ? ST_SOLE : ST_OK;
    tot = (st == ST_OK || st == ST_SOLE) ? s.cmdc + 5'd1 : 5'd0;
    put(e, mk_res(KIND_STMT, 8'd0, 8'd0, 4'd0, 12'd0, st, tot));
    clear_statement(s);
  endfunction

  function automatic void discard_byte(inout lex_t s, inout push_t e,
                                       input logic [7:0] b);
    s.mode = M_DISCARD;
    if (separator(b)) finish_statement(s, e);
  endfunction

  function automatic void at_boundary(inout lex_t s, inout push_t e, input cfg_t c,
                                      input logic [7:0] b);
    if (b == CH_SPACE || b == CH_TAB) return;
    if (separator(b)) begin
      finish_statement(s, e);
      return;
    end
    if (b == CH_SLASH) begin
      s.mode = M_SLASH;
      return;
    end
    if (b == CH_BAR) begin
      if (!s.cmd_seen || ({1'b0, s.cmdc} + 6'd1) >= {1'b0, c.command_limit})
        s.mode = M_DISCARD;
      else
        s.mode = M_PIPE;
      return;
    end
    if (b == CH_QUOTE) begin
      begin_word(s);
      s.mode = M_QUOTE;
      return;
    end
    if (bare_byte(b)) begin
      begin_word(s);
      s.mode = add_char(s, e, c, b) ? M_WORD : M_DISCARD;
      return;
    end
    s.mode = M_DISCARD;
  endfunction

  function automatic void in_word(inout lex_t s, inout push_t e, input cfg_t c,
                                  input logic [7:0] b);
    if (bare_byte(b)) begin
      if (!add_char(s, e, c, b)) s.mode = M_DISCARD;
      return;
    end
    if (end_word(s, e, c)) begin
      s.mode = M_BETWEEN;
      at_boundary(s, e, c, b);
    end else begin
      discard_byte(s, e, b);
    end
  endfunction

  // One full lexer step per accepted item
  always_comb begin
    lex_t  s;
    push_t e;
    logic  ok;
    s  = lex;
    e  = '0;
    ok = 1'b0;
    if (in_eoi) begin
      case (s.mode)
        M_WORD: begin
          if (!end_word(s, e, cfg)) s.mode = M_DISCARD;
        end
        M_SLASH: begin
          s.mode = M_WORD;
          begin_word(s);
          ok = add_char(s, e, cfg, CH_SLASH);
          if (ok) ok = end_word(s, e, cfg);
          if (!ok) s.mode = M_DISCARD;
        end
        M_QUOTE, M_ESC, M_PIPE: s.mode = M_DISCARD;
        default: ;
      endcase
      finish_statement(s, e);
    end else begin
      case (s.mode)
        M_BETWEEN: at_boundary(s, e, cfg, in_byte);
        M_WORD:    in_word(s, e, cfg, in_byte);
        M_QUOTE: begin
          if (in_byte == CH_QUOTE) s.mode = end_word(s, e, cfg) ? M_BETWEEN : M_DISCARD;
          else if (in_byte == CH_BSL) s.mode = M_ESC;
          else if (!add_char(s, e, cfg, in_byte)) discard_byte(s, e, in_byte);
        end
        M_ESC: begin
          if (in_byte == CH_QUOTE || in_byte == CH_BSL) ok = add_char(s, e, cfg, in_byte);
          if (ok) s.mode = M_QUOTE;
          else discard_byte(s, e, in_byte);
        end
        M_SLASH: begin
          if (in_byte == CH_SLASH) begin
            s.mode = M_COMMENT;
          end else begin
            s.mode = M_WORD;
            begin_word(s);
            if (add_char(s, e, cfg, CH_SLASH)) in_word(s, e, cfg, in_byte);
            else discard_byte(s, e, in_byte);
          end
        end
        M_PIPE: begin
          if (in_byte == CH_GT) begin
            if (s.first_st && s.argc == 8'd1) s.sole_seen = 1'b1;
            put(e, mk_res(KIND_PIPE, 8'd0, s.argc, s.cmdc[3:0], 12'd0, ST_OK, 5'd0));
            s.cmdc = s.cmdc + 5'd1;
            clear_command(s);
            s.mode = M_BETWEEN;
          end else begin
            discard_byte(s, e, in_byte);
          end
        end
        M_COMMENT: begin
          if (in_byte == CH_LF) finish_statement(s, e);
        end
        default: discard_byte(s, e, in_byte);
      endcase
    end
    if (e.n != 2'd0) e.r[e.n - 2'd1].last = 1'b1;
    lex_next = s;
    emit     = e;
  end

  assign in_ready = room;
  assign accept   = in_valid && room;

  always_comb begin
    push = emit;
    if (!accept) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex.mode      <= M_BETWEEN;
      lex.wcnt      <= '0;
      lex.argc      <= '0;
      lex.bytes     <= '0;
      lex.cmdc      <= '0;
      lex.cmd_seen  <= 1'b0;
      lex.mpos      <= '0;
      lex.first_st  <= 1'b0;
      lex.sole_seen <= 1'b0;
    end else if (accept) begin
      lex <= lex_next;
    end
  end

endmodule

// ===== hdl/cltok_queue.sv =====
// Result queue: takes up to three results a cycle, hands out one while the output is ready.
module cltok_queue import cltok_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam logic [Q_AW:0] ROOM_MARK = (Q_AW + 1)'(Q_DEPTH - MAX_RES);

  res_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] head, tail;
  logic [Q_AW:0]   count;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[head];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= ROOM_MARK);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.n) mem[tail + Q_AW'(i)] <= push.r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + Q_AW'(push.n);
      head  <= head + Q_AW'(pop);
      count <= count + (Q_AW + 1)'(push.n) - (Q_AW + 1)'(pop);
    end
  end

endmodule

// ===== hdl/command_line_tokenizer_unit.sv =====
// Command-line tokenizer top level: config registers, lexer and result queue.
//
// Streams command text in one byte per item (tuser = 1 marks end of input)
// and streams out tokens: word characters, word ends, "|>" pipe boundaries
// and one status per statement. An item is accepted every cycle as long as
// the 8-entry result queue has room for three more results; each item makes
// zero to three results, and the output side drains one result per cycle
// while m_axis_tready is high, so input runs at one byte per cycle whenever
// the byte stream averages at most one result per byte (typical text), and
// otherwise slows to the output rate. The lexer does a full step in the
// cycle an item is accepted; its results are registered in the result queue.
// tlast marks the last result caused by an input item. Config writes are
// always ready and should only be done while the block is idle.
module command_line_tokenizer_unit import cltok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tuser,  // [0] opcode (1 = end of input)
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [7:0] char_out, [15:8] arg_index,
                                     // [19:16] cmd_index, [31:20] word_length,
                                     // [33:32] stmt_status, [38:34] cmd_total,
                                     // [39] zero pad
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast,  // last_result
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  push_t push;
  logic  room;
  res_t  head_res;

  // Config registers; index as in the register list
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arg_limit      <= 8'd16;
      cfg.word_limit     <= 12'd255;
      cfg.arg_byte_limit <= 16'd4096;
      cfg.command_limit  <= 5'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ARG_LIMIT:      cfg.arg_limit      <= cfg_data[7:0];
        REG_WORD_LIMIT:     cfg.word_limit     <= cfg_data[11:0];
        REG_ARG_BYTE_LIMIT: cfg.arg_byte_limit <= cfg_data;
        REG_COMMAND_LIMIT:  cfg.command_limit  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Front: lexer step per accepted byte
  cltok_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_eoi   (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .room     (room),
    .push     (push)
  );

  // Back: queue decouples multi-result bursts from output stalls
  cltok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (head_res)
  );

  assign m_axis_tdata = {1'b0, head_res.tot, head_res.st, head_res.len,
                         head_res.cmd, head_res.arg, head_res.ch};
  assign m_axis_tuser = head_res.kind;
  assign m_axis_tlast = head_res.last;

endmodule
